// File: src/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, constants and codes for the block bitmap allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int NUM_BLOCKS    = 4096;
    localparam int MAP_WORD_BITS = 32;
    localparam int MAP_WORDS     = NUM_BLOCKS / MAP_WORD_BITS;
    localparam int WORD_IDX_W    = $clog2(MAP_WORDS);
    localparam int BIT_IDX_W     = $clog2(MAP_WORD_BITS);
    localparam int BLK_W         = 12;
    localparam int CNT_W         = 13;

    typedef logic [MAP_WORD_BITS-1:0] word_t;
    typedef logic [WORD_IDX_W-1:0]    widx_t;
    typedef logic [BIT_IDX_W-1:0]     bidx_t;
    typedef logic [BLK_W-1:0]         blk_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [1:0]               op_t;
    typedef logic [1:0]               status_t;

    localparam cnt_t NUM_BLOCKS_CNT = cnt_t'(NUM_BLOCKS);

    localparam op_t OP_ALLOC = 2'd0;
    localparam op_t OP_FREE  = 2'd1;
    localparam op_t OP_TEST  = 2'd2;

    localparam status_t STAT_OK           = 2'd0;
    localparam status_t STAT_NO_FREE      = 2'd1;
    localparam status_t STAT_RANGE        = 2'd2;
    localparam status_t STAT_ALREADY_FREE = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LOOKUP,
        S_RESP
    } state_t;

    typedef struct packed {
        logic  found;
        bidx_t pos;
        logic  bit_val;
    } word_info_t;

endpackage

// File: src/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/bba_map.sv
// ----------------------------------------------------------------------------
// bba_map
// Usage bitmap store: RAM plus per-word valid bits; unwritten words read zero.
// ----------------------------------------------------------------------------
module bba_map (
    input  logic          clk,
    input  logic          rst_n,
    input  bba_pkg::widx_t rd_addr,
    output bba_pkg::word_t rd_word,
    input  logic          wr_en,
    input  bba_pkg::widx_t wr_addr,
    input  bba_pkg::word_t wr_word
);
    import bba_pkg::*;

    logic [MAP_WORDS-1:0] valid_reg;
    logic [MAP_WORDS-1:0] valid_next;
    logic                 rd_valid_reg;
    word_t                ram_rd_data;

    bba_ram #(
        .WIDTH (MAP_WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_word),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_word = rd_valid_reg ? ram_rd_data : '0;

endmodule

// File: src/bba_word_unit.sv
// ----------------------------------------------------------------------------
// bba_word_unit
// Shared word unit: first free bit below the total, bit test, set and clear.
// ----------------------------------------------------------------------------
module bba_word_unit (
    input  bba_pkg::word_t      word,
    input  bba_pkg::widx_t      widx,
    input  bba_pkg::cnt_t       eff_total,
    input  bba_pkg::bidx_t      bit_sel,
    output bba_pkg::word_info_t info,
    output bba_pkg::word_t      set_word,
    output bba_pkg::word_t      clr_word
);
    import bba_pkg::*;

    cnt_t  base;
    cnt_t  rem;
    word_t limit_mask;
    word_t free_bits;
    bidx_t pos;

    assign base = {1'b0, widx, {BIT_IDX_W{1'b0}}};
    assign rem  = (eff_total > base) ? (eff_total - base) : '0;

    always_comb
    begin
        if (rem >= cnt_t'(MAP_WORD_BITS))
        begin
            limit_mask = '1;
        end
        else
        begin
            limit_mask = (word_t'(1) << rem[BIT_IDX_W-1:0]) - word_t'(1);
        end
    end

    assign free_bits = ~word & limit_mask;

    // lowest free bit
    always_comb
    begin
        pos = '0;
        for (int i = MAP_WORD_BITS - 1; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                pos = bidx_t'(i);
            end
        end
    end

    assign info.found   = |free_bits;
    assign info.pos     = pos;
    assign info.bit_val = word[bit_sel];

    assign set_word = word | (word_t'(1) << pos);
    assign clr_word = word & ~(word_t'(1) << bit_sel);

endmodule

// File: src/block_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// block_bitmap_allocator
// First-fit block allocator over a 4096-block used/free bitmap.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall, op, block_index): one request per item,
// allocate, free or test. in_stall is high while a request is in progress.
// Output channel (out_valid/out_stall, block_number, status, bit_value,
// free_count): exactly one result item per request, held in an output
// register while out_stall is high; the next request is taken meanwhile and
// waits for that register before its own result is loaded.
// Configuration (cfg_valid/cfg_ready, total_blocks): always ready; write only
// while no request is in flight.
// Sequence: free and test in range look up one map word and then respond; an
// allocate with no room left, or a request out of range, goes straight to the
// response step; an allocate reads 32-block map words in order up to and
// including the first one with a free block below the total (1 to 128 words)
// and sets that bit. The single map read port, one word per cycle, sets the scan rate.
// Next request: accepted the cycle after the result is loaded into the output
// register.
// Reset: every block free, used count zero, total_blocks 4096; no clearing
// pass, the block is ready right after reset.
// ----------------------------------------------------------------------------
module block_bitmap_allocator (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  bba_pkg::op_t     op,
    input  bba_pkg::blk_t    block_index,
    output logic             out_valid,
    input  logic             out_stall,
    output bba_pkg::blk_t    block_number,
    output bba_pkg::status_t status,
    output logic             bit_value,
    output bba_pkg::cnt_t    free_count,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  bba_pkg::cnt_t    total_blocks
);
    import bba_pkg::*;

    state_t  state_reg, state_next;
    cnt_t    total_reg, total_next;
    cnt_t    used_reg, used_next;
    logic [WORD_IDX_W:0] scan_reg, scan_next;
    logic    chk_valid_reg, chk_valid_next;
    widx_t   chk_addr_reg, chk_addr_next;
    op_t     op_reg, op_next;
    blk_t    idx_reg, idx_next;
    blk_t    num_reg, num_next;
    status_t stat_reg, stat_next;
    logic    bitv_reg, bitv_next;
    logic    out_valid_reg, out_valid_next;
    blk_t    out_num_reg, out_num_next;
    status_t out_stat_reg, out_stat_next;
    logic    out_bitv_reg, out_bitv_next;
    cnt_t    out_free_reg, out_free_next;

    cnt_t       eff_total;
    logic       in_accept;
    logic       alloc_go;
    logic       look_go;
    logic       issue;
    logic       hit;
    logic       scan_fail;
    logic       out_free;
    widx_t      map_rd_addr;
    word_t      map_rd_word;
    logic       map_wr_en;
    widx_t      map_wr_addr;
    word_t      map_wr_word;
    word_info_t info;
    word_t      set_word;
    word_t      clr_word;

    bba_map u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (map_rd_addr),
        .rd_word (map_rd_word),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_word (map_wr_word)
    );

    bba_word_unit u_word (
        .word      (map_rd_word),
        .widx      (chk_addr_reg),
        .eff_total (eff_total),
        .bit_sel   (idx_reg[BIT_IDX_W-1:0]),
        .info      (info),
        .set_word  (set_word),
        .clr_word  (clr_word)
    );

    assign eff_total = (total_reg > NUM_BLOCKS_CNT) ? NUM_BLOCKS_CNT : total_reg;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign alloc_go  = (op == OP_ALLOC) && (used_reg < eff_total);
    assign look_go   = (op inside {OP_FREE, OP_TEST})
                       && ({1'b0, block_index} < eff_total);
    assign issue     = {scan_reg, {BIT_IDX_W{1'b0}}} < eff_total;
    assign hit       = chk_valid_reg && info.found;
    assign scan_fail = !hit && !issue && !chk_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (alloc_go)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (look_go)
                    begin
                        state_next = S_LOOKUP;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_SCAN:
            begin
                if (hit || scan_fail)
                begin
                    state_next = S_RESP;
                end
            end
            S_LOOKUP:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        total_next     = total_reg;
        used_next      = used_reg;
        scan_next      = scan_reg;
        chk_valid_next = chk_valid_reg;
        chk_addr_next  = chk_addr_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        num_next       = num_reg;
        stat_next      = stat_reg;
        bitv_next      = bitv_reg;
        out_valid_next = out_valid_reg;
        out_num_next   = out_num_reg;
        out_stat_next  = out_stat_reg;
        out_bitv_next  = out_bitv_reg;
        out_free_next  = out_free_reg;
        map_rd_addr    = scan_reg[WORD_IDX_W-1:0];
        map_wr_en      = 1'b0;
        map_wr_addr    = chk_addr_reg;
        map_wr_word    = set_word;

        if (cfg_valid && cfg_ready)
        begin
            total_next = total_blocks;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                map_rd_addr = block_index[BLK_W-1:BIT_IDX_W];
                if (in_accept)
                begin
                    op_next        = op;
                    idx_next       = block_index;
                    num_next       = '0;
                    stat_next      = STAT_OK;
                    bitv_next      = 1'b0;
                    scan_next      = '0;
                    chk_valid_next = 1'b0;
                    case (op)
                        OP_ALLOC:
                        begin
                            if (!alloc_go)
                            begin
                                stat_next = STAT_NO_FREE;
                            end
                        end
                        OP_FREE, OP_TEST:
                        begin
                            if (!look_go)
                            begin
                                stat_next = STAT_RANGE;
                            end
                        end
                        default:
                        begin
                            stat_next = STAT_RANGE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    map_wr_en   = 1'b1;
                    map_wr_addr = chk_addr_reg;
                    map_wr_word = set_word;
                    used_next   = used_reg + cnt_t'(1);
                    num_next    = {chk_addr_reg, info.pos};
                end
                else if (issue)
                begin
                    scan_next      = scan_reg + {{WORD_IDX_W{1'b0}}, 1'b1};
                    chk_addr_next  = scan_reg[WORD_IDX_W-1:0];
                    chk_valid_next = 1'b1;
                end
                else
                begin
                    chk_valid_next = 1'b0;
                    if (!chk_valid_reg)
                    begin
                        stat_next = STAT_NO_FREE;
                    end
                end
            end
            S_LOOKUP:
            begin
                if (op_reg == OP_TEST)
                begin
                    num_next  = idx_reg;
                    bitv_next = info.bit_val;
                end
                else if (!info.bit_val)
                begin
                    stat_next = STAT_ALREADY_FREE;
                end
                else
                begin
                    map_wr_en   = 1'b1;
                    map_wr_addr = idx_reg[BLK_W-1:BIT_IDX_W];
                    map_wr_word = clr_word;
                    num_next    = idx_reg;
                    if (used_reg != '0)
                    begin
                        used_next = used_reg - cnt_t'(1);
                    end
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_num_next   = num_reg;
                    out_stat_next  = stat_reg;
                    out_bitv_next  = bitv_reg;
                    out_free_next  = (used_reg < eff_total) ? (eff_total - used_reg) : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= NUM_BLOCKS_CNT;
            used_reg      <= '0;
            scan_reg      <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            used_reg      <= used_next;
            scan_reg      <= scan_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_addr_reg <= chk_addr_next;
        op_reg       <= op_next;
        idx_reg      <= idx_next;
        num_reg      <= num_next;
        stat_reg     <= stat_next;
        bitv_reg     <= bitv_next;
        out_num_reg  <= out_num_next;
        out_stat_reg <= out_stat_next;
        out_bitv_reg <= out_bitv_next;
        out_free_reg <= out_free_next;
    end

    assign out_valid    = out_valid_reg;
    assign block_number = out_num_reg;
    assign status       = out_stat_reg;
    assign bit_value    = out_bitv_reg;
    assign free_count   = out_free_reg;

`ifndef NO_ASSERTIONS
    a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= NUM_BLOCKS_CNT)
        else $error("used count above block count");

    a_used_follows_write: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != $past(used_reg)) |-> $past(map_wr_en))
        else $error("used count changed without a map write");

    a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("result loaded outside response step");

    a_write_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        map_wr_en |-> ((state_reg == S_SCAN) || (state_reg == S_LOOKUP)))
        else $error("map written while idle");
`endif

endmodule
